/* rtl/olid_pkg.sv */
package olid_pkg;

  localparam int VALUE_W = 32;

  // operation codes
  localparam logic [2:0] OP_INS_FRONT = 3'd0;
  localparam logic [2:0] OP_INS_BACK  = 3'd1;
  localparam logic [2:0] OP_DEL_FRONT = 3'd2;
  localparam logic [2:0] OP_DEL_BACK  = 3'd3;
  localparam logic [2:0] OP_DEL_KEY   = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // per-cycle move broadcast to the cell row
  localparam logic [1:0] MOVE_HOLD       = 2'd0;
  localparam logic [1:0] MOVE_PUSH_FRONT = 2'd1;
  localparam logic [1:0] MOVE_PUSH_BACK  = 2'd2;
  localparam logic [1:0] MOVE_PULL       = 2'd3;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [VALUE_W-1:0] operand_value;
  } olid_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] deleted_value;
    logic [4:0]                entry_count;
  } olid_out_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [VALUE_W-1:0] operand;
  } cell_cmd_t;

endpackage

/* rtl/olid_cell.sv */
module olid_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 5
) (
  input  logic                               clk,
  input  olid_pkg::cell_cmd_t                cmd,
  input  logic [CNT_W-1:0]                   len,
  input  logic signed [olid_pkg::VALUE_W-1:0] left,
  input  logic signed [olid_pkg::VALUE_W-1:0] right,
  input  logic                               pull,
  output logic signed [olid_pkg::VALUE_W-1:0] value,
  output logic                               hit,
  output logic signed [olid_pkg::VALUE_W-1:0] tap
);
  import olid_pkg::*;

  logic in_use;
  logic is_last;

  assign in_use  = CNT_W'(INDEX) < len;
  assign is_last = len == CNT_W'(INDEX + 1);
  assign hit     = in_use && (value == cmd.operand);
  assign tap     = is_last ? value : '0;

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      MOVE_PUSH_FRONT: value <= left;
      MOVE_PUSH_BACK: begin
        if (len == CNT_W'(INDEX)) value <= cmd.operand;
      end
      MOVE_PULL: begin
        // close the gap: this cell and all behind it take from the right
        if (pull) value <= right;
      end
      default: value <= value;
    endcase
  end

endmodule

/* rtl/olid_prefix.sv */
module olid_prefix #(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0] hits,
  output logic [DEPTH-1:0] from_hit,
  output logic             any
);

  // inclusive prefix OR from the front, doubling the span each level
  always_comb begin
    from_hit = hits;
    for (int s = 1; s < DEPTH; s = s * 2) begin
      from_hit = from_hit | (from_hit << s);
    end
  end

  assign any = from_hit[DEPTH-1];

endmodule

/* rtl/ordered_list_insert_delete.sv */
// Ordered list of up to DEPTH signed 32-bit values kept as a row of cells,
// position 0 at the front. Each beat on the input is one operation (insert
// front, insert back, delete front, delete back, delete first match of a
// key) and yields exactly one result beat with status, deleted value and the
// new count. The whole row shifts, compares and compacts in the cycle that
// the beat is taken, and the result lands in an output register in the
// cycle after the input beat is taken. One operation per cycle is sustained;
// the input stalls only while a result sits unread under an output stall.
// Stored entries are not cleared by reset; only the count and out_valid are.
module ordered_list_insert_delete #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  olid_pkg::olid_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output olid_pkg::olid_out_t out_data
);
  import olid_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] len_next;
  logic             accept;
  logic             full;
  logic             empty;

  cell_cmd_t        cmd;
  logic [DEPTH-1:0] pull_mask;
  logic [DEPTH-1:0] hits;
  logic [DEPTH-1:0] from_hit;
  logic             any_hit;
  logic signed [VALUE_W-1:0] vals [DEPTH];
  logic signed [VALUE_W-1:0] taps [DEPTH];
  logic signed [VALUE_W-1:0] back_value;
  olid_out_t        res;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign full     = len == CNT_W'(DEPTH);
  assign empty    = len == '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] left_in;
    logic signed [VALUE_W-1:0] right_in;
    if (i == 0) begin : g_front
      assign left_in = in_data.operand_value;
    end else begin : g_mid
      assign left_in = vals[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right_in = vals[i];
    end else begin : g_inner
      assign right_in = vals[i+1];
    end
    olid_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .len   (len),
      .left  (left_in),
      .right (right_in),
      .pull  (pull_mask[i]),
      .value (vals[i]),
      .hit   (hits[i]),
      .tap   (taps[i])
    );
  end

  olid_prefix #(
    .DEPTH (DEPTH)
  ) u_prefix (
    .hits     (hits),
    .from_hit (from_hit),
    .any      (any_hit)
  );

  // only the back cell drives its tap, so OR picks it out
  always_comb begin
    back_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_value = back_value | taps[i];
    end
  end

  always_comb begin
    cmd.kind          = MOVE_HOLD;
    cmd.operand       = in_data.operand_value;
    pull_mask         = '1;
    len_next          = len;
    res.status        = ST_OK;
    res.deleted_value = '0;
    unique case (in_data.opcode)
      OP_INS_FRONT, OP_INS_BACK: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          cmd.kind = (in_data.opcode == OP_INS_FRONT) ? MOVE_PUSH_FRONT : MOVE_PUSH_BACK;
          len_next = len + CNT_W'(1);
        end
      end
      OP_DEL_FRONT: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          cmd.kind          = MOVE_PULL;
          res.deleted_value = vals[0];
          len_next          = len - CNT_W'(1);
        end
      end
      OP_DEL_BACK: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.deleted_value = back_value;
          len_next          = len - CNT_W'(1);
        end
      end
      OP_DEL_KEY: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else if (!any_hit) begin
          res.status = ST_NOTFOUND;
        end else begin
          cmd.kind          = MOVE_PULL;
          pull_mask         = from_hit;
          res.deleted_value = in_data.operand_value;
          len_next          = len - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 5'(len_next);
    // hold the row unless a beat is really taken
    if (!accept) begin
      cmd.kind = MOVE_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        len       <= len_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_data <= res;
  end

  a_len_bound : assert property (@(posedge clk) disable iff (rst)
    len <= CNT_W'(DEPTH))
    else $error("count above depth");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted beat gave no result");

  a_insert_grows : assert property (@(posedge clk) disable iff (rst)
    (accept && !full && (in_data.opcode == OP_INS_FRONT || in_data.opcode == OP_INS_BACK))
    |=> len == $past(len) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_miss_keeps : assert property (@(posedge clk) disable iff (rst)
    (accept && !empty && !any_hit && in_data.opcode == OP_DEL_KEY)
    |=> (len == $past(len) && out_data.status == ST_NOTFOUND))
    else $error("key miss changed the count");

  a_empty_count : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_EMPTY) |-> out_data.entry_count == 5'd0)
    else $error("empty status with non-zero count");

endmodule
